FILE: rtl/bsid_pkg.sv
package bsid_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;

    // operation codes
    localparam logic [2:0] OP_PUSH_HEAD = 3'd0;
    localparam logic [2:0] OP_PUSH_TAIL = 3'd1;
    localparam logic [2:0] OP_POP_HEAD  = 3'd2;
    localparam logic [2:0] OP_REVERSE   = 3'd3;
    localparam logic [2:0] OP_INSERT    = 3'd4;
    localparam logic [2:0] OP_DUMP      = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_DUP   = 2'd3;

    typedef struct packed {
        logic [2:0]                op;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] item_value;
        logic                      last;
    } rsp_t;

endpackage

FILE: rtl/bsid_ram.sv
module bsid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read-first, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/bounded_sorted_int_deque_top.sv
// Push, pop, reverse and unused codes register their result at accept, valid the next cycle;
// ordered insert scans every entry, moves each entry above the insert point up one slot, then
// writes the value; a duplicate or full store ends after the scan. Dump reads its first entry,
// then gives one per cycle while rsp is not stalled. Throughput: a request is taken only when
// the sequencer is idle and the result register is free, so at best one short request per cycle.
// Reset (rst_n low, async) empties the list and clears the reverse flag; RAM is not cleared.
module bounded_sorted_int_deque_top #(
    parameter int CAPACITY = bsid_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bsid_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bsid_pkg::rsp_t rsp
);

    import bsid_pkg::*;

    localparam int AW = $clog2(CAPACITY);       // RAM address / entry index
    localparam int CW = $clog2(CAPACITY + 1);   // entry count 0..CAPACITY

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_PUT   = 3'd3;
    localparam logic [2:0] S_DUMP  = 3'd4;

    // Storage is a circular buffer: S[j] lives at (head + j) mod CAPACITY.
    // Logical order is S when rev_reg is low, S read backwards when high.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, hd} + {1'b0, off};
        if (sum >= (AW+1)'(CAPACITY))
        begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    logic [2:0]                state_reg, state_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [AW-1:0]             head_reg, head_next;
    logic                      rev_reg, rev_next;
    logic [AW-1:0]             idx_reg, idx_next;
    logic [CW-1:0]             k_reg, k_next;          // insert point as an S index
    logic                      found_reg, found_next;
    logic                      dup_reg, dup_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    rsp_t                      rsp_reg, rsp_next;

    // RAM port
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [VALUE_W-1:0]        wr_data;
    logic [AW-1:0]             rd_addr;
    logic signed [VALUE_W-1:0] rd_data;

    logic                      rsp_free;
    logic                      accept;
    logic                      load_rsp;
    logic [1:0]                ld_status;
    logic signed [VALUE_W-1:0] ld_value;
    logic                      ld_last;

    // shared compare unit, used during the insert scan
    logic                      cmp_eq;
    logic                      cmp_lt;

    logic [CW-1:0]             cnt_m1;
    logic [AW-1:0]             last_idx;
    logic                      is_full;
    logic                      is_empty;
    logic [CW-1:0]             kk;

    bsid_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE) || !rsp_free;
    assign accept    = req_valid && !req_stall;

    assign cnt_m1   = cnt_reg - CW'(1);
    assign last_idx = cnt_m1[AW-1:0];
    assign is_full  = (cnt_reg == CW'(CAPACITY));
    assign is_empty = (cnt_reg == '0);

    assign cmp_eq = (rd_data == val_reg);
    assign cmp_lt = (rd_data < val_reg);

    // logical position -> S index
    function automatic logic [AW-1:0] l2s(input logic rv, input logic [AW-1:0] top,
                                           input logic [AW-1:0] i);
        return rv ? (top - i) : i;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        head_next  = head_reg;
        rev_next   = rev_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        found_next = found_reg;
        dup_next   = dup_reg;
        val_next   = val_reg;
        kk         = k_reg;

        wr_en   = 1'b0;
        wr_addr = head_reg;
        wr_data = req.value;
        rd_addr = phys(head_reg, idx_reg);

        load_rsp  = 1'b0;
        ld_status = ST_OK;
        ld_value  = '0;
        ld_last   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.op)
                        OP_PUSH_HEAD, OP_PUSH_TAIL:
                        begin
                            load_rsp = 1'b1;
                            if (is_full)
                            begin
                                ld_status = ST_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                                // logical front is S head unless reversed
                                if ((req.op == OP_PUSH_HEAD) != rev_reg)
                                begin
                                    head_next = (head_reg == '0) ? AW'(CAPACITY - 1)
                                                                 : head_reg - AW'(1);
                                    wr_addr   = head_next;
                                end
                                else
                                begin
                                    wr_addr = phys(head_reg, cnt_reg[AW-1:0]);
                                end
                            end
                        end
                        OP_POP_HEAD:
                        begin
                            load_rsp = 1'b1;
                            if (is_empty)
                            begin
                                ld_status = ST_EMPTY;
                            end
                            else
                            begin
                                cnt_next = cnt_m1;
                                if (!rev_reg)
                                begin
                                    head_next = phys(head_reg, AW'(1));
                                end
                            end
                        end
                        OP_REVERSE:
                        begin
                            load_rsp = 1'b1;
                            rev_next = !rev_reg;
                        end
                        OP_INSERT:
                        begin
                            val_next   = req.value;
                            dup_next   = 1'b0;
                            found_next = 1'b0;
                            if (is_empty)
                            begin
                                k_next     = '0;
                                state_next = S_PUT;
                            end
                            else
                            begin
                                idx_next   = '0;
                                rd_addr    = phys(head_reg, '0);
                                // no entry >= value: end of logical order
                                k_next     = rev_reg ? '0 : cnt_reg;
                                state_next = S_SCAN;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (is_empty)
                            begin
                                load_rsp  = 1'b1;
                                ld_status = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                rd_addr    = phys(head_reg, l2s(rev_reg, last_idx, '0));
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            load_rsp = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // rd_data holds S[idx_reg]
                dup_next = dup_reg || cmp_eq;
                if (!cmp_lt)
                begin
                    if (rev_reg)
                    begin
                        kk = CW'(idx_reg) + CW'(1);     // after the last S entry >= value
                    end
                    else if (!found_reg)
                    begin
                        kk         = CW'(idx_reg);      // first S entry >= value
                        found_next = 1'b1;
                    end
                end
                k_next = kk;
                if (idx_reg != last_idx)
                begin
                    idx_next = idx_reg + AW'(1);
                    rd_addr  = phys(head_reg, idx_reg + AW'(1));
                end
                else
                begin
                    rd_addr = phys(head_reg, idx_reg);  // primes the move pass
                    if (dup_next)
                    begin
                        load_rsp   = 1'b1;
                        ld_status  = ST_DUP;
                        state_next = S_IDLE;
                    end
                    else if (is_full)
                    begin
                        load_rsp   = 1'b1;
                        ld_status  = ST_FULL;
                        state_next = S_IDLE;
                    end
                    else if (kk == cnt_reg)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                // move S[idx] up one slot, walking down to the insert point
                wr_en   = 1'b1;
                wr_addr = phys(head_reg, idx_reg + AW'(1));
                wr_data = rd_data;
                if (CW'(idx_reg) == k_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    idx_next = idx_reg - AW'(1);
                    rd_addr  = phys(head_reg, idx_reg - AW'(1));
                end
            end

            S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = phys(head_reg, k_reg[AW-1:0]);
                wr_data    = val_reg;
                cnt_next   = cnt_reg + CW'(1);
                load_rsp   = 1'b1;
                state_next = S_IDLE;
            end

            S_DUMP:
            begin
                // rd_data holds logical entry idx_reg; address held while stalled
                rd_addr = phys(head_reg, l2s(rev_reg, last_idx, idx_reg));
                if (rsp_free)
                begin
                    load_rsp = 1'b1;
                    ld_value = rd_data;
                    ld_last  = (idx_reg == last_idx);
                    if (idx_reg == last_idx)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                        rd_addr  = phys(head_reg, l2s(rev_reg, last_idx, idx_reg + AW'(1)));
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_next = rsp_reg;
        if (load_rsp)
        begin
            rsp_next.status     = ld_status;
            rsp_next.item_value = ld_value;
            rsp_next.last       = ld_last;
        end

        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            head_reg      <= '0;
            rev_reg       <= 1'b0;
            found_reg     <= 1'b0;
            dup_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            head_reg      <= head_next;
            rev_reg       <= rev_next;
            found_reg     <= found_next;
            dup_reg       <= dup_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        k_reg   <= k_next;
        val_reg <= val_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
